>>> hw/rtl/deq_pkg.sv
// shared types and codes for the double-ended queue
// operation and status codes, controller/datapath command and status structs
// no dependencies
`timescale 1ns / 1ps

package deq_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_POP_FRONT  = 3'd1;
    localparam logic [2:0] OP_READ_FWD   = 3'd2;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;
    localparam logic [2:0] OP_READ_BWD   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
    } deq_cmd_t;

    typedef struct packed {
        logic read_go;
        logic read_last;
    } deq_stat_t;

endpackage

>>> hw/rtl/deq_ctrl.sv
// controller state machine for the double-ended queue
// depends on deq_pkg for the command and status structs
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_cmd_t  cmd,
    output logic               busy
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.step    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.read_go)
                    state_next = S_READ;
                else
                    state_next = S_IDLE;
            end
            S_READ:
            begin
                cmd.step = 1'b1;
                if (stat.read_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hw/rtl/deq_datapath.sv
// datapath for the double-ended queue: ring storage, pointers, occupancy, result registers
// depends on deq_pkg for codes and the command and status structs
`timescale 1ns / 1ps

module deq_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::deq_cmd_t  cmd,
    output deq_pkg::deq_stat_t stat,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    output logic               strobe,
    output logic signed [31:0] element,
    output logic [1:0]         status,
    output logic               last
);
    import deq_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
        if (idx == IW'(CAPACITY - 1))
            return '0;
        else
            return idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx);
        if (idx == '0)
            return IW'(CAPACITY - 1);
        else
            return idx - IW'(1);
    endfunction

    logic signed [31:0] mem [CAPACITY];

    logic [2:0]         op_reg, op_next;
    logic signed [31:0] value_reg, value_next;
    logic [IW-1:0]      front_reg, front_next;
    logic [IW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      walk_reg, walk_next;
    logic [CW-1:0]      remain_reg, remain_next;
    logic               stat_strobe_reg, stat_strobe_next;
    logic [1:0]         stat_reg, stat_next;
    logic               rd_pending_reg, rd_pending_next;
    logic               rd_last_reg, rd_last_next;
    logic signed [31:0] rd_data_reg;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          full;
    logic          empty;
    logic          fwd;

    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);
    assign fwd   = (op_reg == OP_READ_FWD);

    assign stat.read_go   = ((op_reg == OP_READ_FWD) || (op_reg == OP_READ_BWD)) && !empty;
    assign stat.read_last = (remain_reg == CW'(1));

    always_comb
    begin
        op_next          = op_reg;
        value_next       = value_reg;
        front_next       = front_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        walk_next        = walk_reg;
        remain_next      = remain_reg;
        stat_strobe_next = 1'b0;
        stat_next        = stat_reg;
        rd_pending_next  = 1'b0;
        rd_last_next     = rd_last_reg;
        wr_en            = 1'b0;
        wr_addr          = tail_reg;

        if (cmd.capture)
        begin
            op_next    = operation;
            value_next = value;
        end

        if (cmd.exec)
        begin
            case (op_reg) inside
                OP_PUSH_FRONT:
                begin
                    stat_strobe_next = 1'b1;
                    if (full)
                        stat_next = ST_OVER;
                    else
                    begin
                        stat_next  = ST_OK;
                        wr_en      = 1'b1;
                        wr_addr    = idx_dec(front_reg);
                        front_next = idx_dec(front_reg);
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_PUSH_BACK:
                begin
                    stat_strobe_next = 1'b1;
                    if (full)
                        stat_next = ST_OVER;
                    else
                    begin
                        stat_next  = ST_OK;
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        tail_next  = idx_inc(tail_reg);
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_POP_FRONT:
                begin
                    stat_strobe_next = 1'b1;
                    if (empty)
                        stat_next = ST_UNDER;
                    else
                    begin
                        stat_next  = ST_OK;
                        front_next = idx_inc(front_reg);
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_POP_BACK:
                begin
                    stat_strobe_next = 1'b1;
                    if (empty)
                        stat_next = ST_UNDER;
                    else
                    begin
                        stat_next  = ST_OK;
                        tail_next  = idx_dec(tail_reg);
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_READ_FWD, OP_READ_BWD:
                begin
                    if (empty)
                    begin
                        stat_strobe_next = 1'b1;
                        stat_next        = ST_UNDER;
                    end
                    else
                    begin
                        // tail points one past the back entry
                        walk_next   = fwd ? front_reg : idx_dec(tail_reg);
                        remain_next = count_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.step)
        begin
            walk_next       = fwd ? idx_inc(walk_reg) : idx_dec(walk_reg);
            remain_next     = remain_reg - CW'(1);
            rd_pending_next = 1'b1;
            rd_last_next    = (remain_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg       <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            stat_strobe_reg <= 1'b0;
            rd_pending_reg  <= 1'b0;
        end
        else
        begin
            front_reg       <= front_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            stat_strobe_reg <= stat_strobe_next;
            rd_pending_reg  <= rd_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        value_reg   <= value_next;
        walk_reg    <= walk_next;
        remain_reg  <= remain_next;
        stat_reg    <= stat_next;
        rd_last_reg <= rd_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= value_reg;
        if (cmd.step)
            rd_data_reg <= mem[walk_reg];
    end

    assign strobe  = stat_strobe_reg | rd_pending_reg;
    assign element = rd_pending_reg ? rd_data_reg : '0;
    assign status  = rd_pending_reg ? ST_OK : stat_reg;
    assign last    = rd_pending_reg ? rd_last_reg : 1'b1;

endmodule

>>> hw/rtl/double_ended_queue.sv
// top level of the bounded double-ended queue of signed 32-bit values
// depends on deq_pkg, deq_ctrl and deq_datapath
// A command is taken when start is high and busy is low. Push and pop commands
// each give one status result, registered in the execute state; busy is high
// only in that state, so a new command can be taken once it has passed. A read
// gives one result per stored entry, one per cycle, and holds busy through the
// execute and read states; the single read port of the entry memory sets the
// one-entry-per-cycle pace. A read of an empty queue gives one underflow result,
// like a pop. Operation codes six and seven give no result. Results are shown for
// exactly one cycle under strobe and cannot be held off, so the receiver must
// take every one as it comes.
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    output logic               strobe,
    output logic signed [31:0] element,
    output logic [1:0]         status,
    output logic               last
);
    import deq_pkg::*;

    deq_cmd_t  cmd;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    deq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .operation (operation),
        .value     (value),
        .strobe    (strobe),
        .element   (element),
        .status    (status),
        .last      (last)
    );

    // push and pop transactions answer with one final status result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_PUSH_FRONT || operation == OP_POP_FRONT ||
                            operation == OP_PUSH_BACK || operation == OP_POP_BACK))
        |-> ##2 (strobe && last))
    else $error("push or pop result missing");

    // unused operation codes give no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation != OP_PUSH_FRONT) && (operation != OP_POP_FRONT) &&
         (operation != OP_READ_FWD) && (operation != OP_PUSH_BACK) &&
         (operation != OP_POP_BACK) && (operation != OP_READ_BWD))
        |-> ##2 !strobe)
    else $error("result from unused operation code");

    // read results come back to back until the last one
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
    else $error("gap in read results");

    // error results are always final and carry no element
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status != ST_OK)) |-> (last && (element == '0)))
    else $error("malformed error result");

endmodule

>>> sim/tb_double_ended_queue.sv
// self-checking testbench for double_ended_queue: directed corner transactions, then random
// fill/drain/mixed traffic, with every strobed result checked against an in-bench deque model
// depends on deq_pkg and double_ended_queue
`timescale 1ns / 1ps

module tb_double_ended_queue;

    import deq_pkg::*;

    localparam int DEPTH        = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;

    // codes outside the operation set, the block drops them
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] val;
        int                 gap;
        bit                 drain;
    } deque_cmd_t;

    typedef struct {
        logic signed [31:0] element;
        logic [1:0]         status;
        logic               last;
    } deque_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         operation = OP_PUSH_FRONT;
    logic signed [31:0] value = '0;
    logic               busy;
    logic               strobe;
    logic signed [31:0] element;
    logic [1:0]         status;
    logic               last;

    deque_cmd_t    pending_cmds[$];
    deque_result_t owed_results[$];

    // model state
    logic signed [31:0] mdl_slots [DEPTH];
    logic [5:0]         mdl_head = '0;
    logic [6:0]         mdl_count = '0;

    int         accepted_cnt = 0;
    int         issued_cnt = 0;
    int         fault_cnt = 0;
    int         cycle_cnt = 0;
    int         gap_left = 0;
    bit         staged = 1'b0;
    deque_cmd_t next_cmd;

    // generator bookkeeping
    int gen_occ = 0;
    bit idle_on = 1'b1;
    bit drain_next = 1'b0;

    double_ended_queue #(
        .CAPACITY (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .value     (value),
        .strobe    (strobe),
        .element   (element),
        .status    (status),
        .last      (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic deque_step(input logic [2:0] op, input logic signed [31:0] val);
        deque_result_t r;
        logic [5:0]    pos;
        int            n;
        int            off;
        r.element = '0;
        r.status  = ST_OK;
        r.last    = 1'b1;
        n = int'(mdl_count);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (n >= DEPTH)
                    r.status = ST_OVER;
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        mdl_head = mdl_head - 6'd1;
                        mdl_slots[mdl_head] = val;
                    end
                    else
                    begin
                        pos = mdl_head + mdl_count[5:0];
                        mdl_slots[pos] = val;
                    end
                    mdl_count = mdl_count + 7'd1;
                end
                owed_results.push_back(r);
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (n == 0)
                    r.status = ST_UNDER;
                else
                begin
                    if (op == OP_POP_FRONT)
                        mdl_head = mdl_head + 6'd1;
                    mdl_count = mdl_count - 7'd1;
                end
                owed_results.push_back(r);
            end
            OP_READ_FWD, OP_READ_BWD:
            begin
                if (n == 0)
                begin
                    r.status = ST_UNDER;
                    owed_results.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        off = (op == OP_READ_FWD) ? i : (n - 1 - i);
                        pos = mdl_head + 6'(off);
                        r.element = mdl_slots[pos];
                        r.last = (i == n - 1);
                        owed_results.push_back(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] w;
        case ($urandom_range(0, 9))
            0: w = 32'sh7FFF_FFFF;
            1: w = 32'sh8000_0000;
            2: w = 32'sh0000_0000;
            3: w = -32'sd1;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic add_cmd(input logic [2:0] op, input logic signed [31:0] val);
        deque_cmd_t c;
        c.op    = op;
        c.val   = val;
        c.gap   = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        c.drain = drain_next;
        drain_next = 1'b0;
        pending_cmds.push_back(c);
        if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_occ < DEPTH)
            gen_occ++;
        else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && gen_occ > 0)
            gen_occ--;
    endtask

    task automatic add_push();
        add_cmd($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_word());
    endtask

    task automatic add_pop();
        add_cmd($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, rand_word());
    endtask

    task automatic add_read();
        add_cmd($urandom_range(0, 1) ? OP_READ_BWD : OP_READ_FWD, rand_word());
    endtask

    task automatic add_mixed(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                add_push();
            else if (pick < 74)
                add_pop();
            else if (pick < 92)
                add_read();
            else if (pick < 95)
                add_cmd($urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6, rand_word());
            else
                add_push();
        end
    endtask

    // push until full, then overflow on both ends and read the full queue both ways
    task automatic add_fill();
        while (gen_occ < DEPTH)
        begin
            if ($urandom_range(0, 15) == 0)
                add_read();
            else
                add_push();
        end
        add_cmd(OP_PUSH_FRONT, rand_word());
        add_cmd(OP_PUSH_BACK, rand_word());
        add_cmd(OP_READ_FWD, rand_word());
        add_cmd(OP_READ_BWD, rand_word());
    endtask

    task automatic add_drain();
        while (gen_occ > 0)
        begin
            if ($urandom_range(0, 15) == 0)
                add_read();
            else
                add_pop();
        end
        add_cmd(OP_POP_FRONT, rand_word());
        add_cmd(OP_POP_BACK, rand_word());
        add_cmd(OP_READ_FWD, rand_word());
    endtask

    // stimulus and end of run
    initial
    begin
        // directed corners: empty queue, spare codes, field extremes, ring wrap at the front
        add_cmd(OP_READ_FWD, 32'sh0);
        add_cmd(OP_READ_BWD, -32'sd1);
        add_cmd(OP_POP_FRONT, 32'sh7FFF_FFFF);
        add_cmd(OP_POP_BACK, 32'sh8000_0000);
        add_cmd(OP_SPARE_6, 32'sh1234_5678);
        add_cmd(OP_SPARE_7, -32'sd1);
        add_cmd(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        add_cmd(OP_PUSH_BACK, 32'sh8000_0000);
        add_cmd(OP_PUSH_FRONT, 32'sh0);
        add_cmd(OP_PUSH_BACK, -32'sd1);
        add_cmd(OP_READ_FWD, 32'sh0);
        add_cmd(OP_READ_BWD, 32'sh0);
        add_cmd(OP_POP_FRONT, -32'sd1);
        add_cmd(OP_READ_FWD, 32'sh0);
        add_cmd(OP_POP_BACK, 32'sh0);
        add_cmd(OP_READ_BWD, 32'sh0);
        add_cmd(OP_PUSH_BACK, 32'sh5555_AAAA);
        add_cmd(OP_PUSH_FRONT, 32'shAAAA_5555);
        add_cmd(OP_READ_FWD, 32'sh0);
        add_cmd(OP_POP_FRONT, 32'sh0);
        add_cmd(OP_POP_FRONT, 32'sh0);
        add_cmd(OP_POP_BACK, 32'sh0);
        add_cmd(OP_POP_BACK, 32'sh0);
        add_cmd(OP_READ_BWD, 32'sh0);

        drain_next = 1'b1;
        add_mixed(50);
        add_fill();
        drain_next = 1'b1;
        add_drain();
        add_mixed(40);
        add_fill();
        // closing stretch runs without idle cycles
        idle_on = 1'b0;
        drain_next = 1'b1;
        add_mixed(40);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || staged || accepted_cnt != issued_cnt)
            @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (fault_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // driver: presents one transaction at a time, changes inputs on the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!start || accepted_cnt == issued_cnt))
        begin
            if (!staged && pending_cmds.size() != 0)
            begin
                next_cmd = pending_cmds.pop_front();
                gap_left = next_cmd.gap;
                staged = 1'b1;
            end
            if (!staged)
                start <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (next_cmd.drain && owed_results.size() != 0)
                start <= 1'b0;
            else
            begin
                operation <= next_cmd.op;
                value     <= next_cmd.val;
                start     <= 1'b1;
                issued_cnt++;
                staged = 1'b0;
            end
        end
    end

    // monitor: checks strobed results, then models each accepted transaction
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && strobe)
        begin
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: element %0d status %0d last %0d",
                       element, status, last);
                fault_cnt++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (element !== want.element)
                begin
                    $error("element: expected %0d, got %0d", want.element, element);
                    fault_cnt++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fault_cnt++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    fault_cnt++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            accepted_cnt++;
            deque_step(operation, value);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
